### src/r2fft_pkg.sv
`timescale 1ns / 1ps
package r2fft_pkg;
  localparam int MAX_POINTS_DEF   = 64;
  localparam int TWIDDLE_BITS_DEF = 16;
  localparam int IN_W    = 16;
  localparam int STORE_W = 23;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOG2    = 1'd1;

  typedef logic signed [STORE_W-1:0] store_t;

  // cos(2*pi*r/64), r = 0..16, Q1.23
  function automatic logic [23:0] quarter_cos(input logic [4:0] r);
    logic [23:0] v;
    unique case (r)
      5'd0: v = 24'd8388608;  5'd1: v = 24'd8348215;  5'd2: v = 24'd8227423;
      5'd3: v = 24'd8027397;  5'd4: v = 24'd7750063;  5'd5: v = 24'd7398092;
      5'd6: v = 24'd6974873;  5'd7: v = 24'd6484482;  5'd8: v = 24'd5931642;
      5'd9: v = 24'd5321677;  5'd10: v = 24'd4660461; 5'd11: v = 24'd3954362;
      5'd12: v = 24'd3210181; 5'd13: v = 24'd2435084; 5'd14: v = 24'd1636536;
      5'd15: v = 24'd822227;  default: v = 24'd0;
    endcase
    return v;
  endfunction

  // magnitude of cos(2*pi*t/64) with its sign flag
  function automatic logic [24:0] cos_q23(input logic [5:0] t);
    logic [1:0] q;
    logic [3:0] r;
    logic [4:0] ri;
    logic       neg;
    q = t[5:4];
    r = t[3:0];
    ri = (q == 2'd0 || q == 2'd2) ? {1'b0, r} : 5'd16 - {1'b0, r};
    neg = (q == 2'd1 || q == 2'd2);
    return {neg, quarter_cos(ri)};
  endfunction

  function automatic store_t sat23(input logic signed [STORE_W+1:0] v);
    if (v > $signed({3'b000, {(STORE_W-1){1'b1}}})) return store_t'({1'b0, {(STORE_W-1){1'b1}}});
    if (v < $signed({3'b111, {(STORE_W-1){1'b0}}})) return store_t'({1'b1, {(STORE_W-1){1'b0}}});
    return v[STORE_W-1:0];
  endfunction
endpackage

### src/r2fft_if.sv
`timescale 1ns / 1ps
interface r2fft_if #(parameter int W = 32) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/r2fft_bfly.sv
`timescale 1ns / 1ps
// Butterfly datapath: registered multiplies, then combinational rounding, adds and saturation.
module r2fft_bfly #(
  parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic signed [TWIDDLE_BITS-1:0]       wr,
  input  logic signed [TWIDDLE_BITS-1:0]       wi,
  input  r2fft_pkg::store_t                    ar,
  input  r2fft_pkg::store_t                    ai,
  input  r2fft_pkg::store_t                    br,
  input  r2fft_pkg::store_t                    bi,
  output r2fft_pkg::store_t                    pr,
  output r2fft_pkg::store_t                    pi,
  output r2fft_pkg::store_t                    qr,
  output r2fft_pkg::store_t                    qi
);
  import r2fft_pkg::*;
  localparam int PW = STORE_W + TWIDDLE_BITS;
  localparam int FB = TWIDDLE_BITS - 1;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] m_rr, m_ii, m_ri, m_ir;
  store_t ar_d, ai_d;
  logic signed [SW-1:0] sr, si, sr_r, si_r;
  logic signed [STORE_W+1:0] or_v, oi_v;

  // full-width products: PW = STORE_W + TWIDDLE_BITS holds any signed product
  always_ff @(posedge clk) begin
    m_rr <= wr * br;
    m_ii <= wi * bi;
    m_ri <= wr * bi;
    m_ir <= wi * br;
    ar_d <= ar;
    ai_d <= ai;
  end

  always_comb begin
    sr = SW'(m_rr) - SW'(m_ii) + (SW'(1) <<< (FB - 1));
    si = SW'(m_ri) + SW'(m_ir) + (SW'(1) <<< (FB - 1));
    sr_r = sr >>> FB;
    si_r = si >>> FB;
    // product never exceeds store range by more than a bit or two
    or_v = (STORE_W+2)'(sr_r);
    oi_v = (STORE_W+2)'(si_r);
    pr = sat23((STORE_W+2)'(ar_d) + or_v);
    pi = sat23((STORE_W+2)'(ai_d) + oi_v);
    qr = sat23((STORE_W+2)'(ar_d) - or_v);
    qi = sat23((STORE_W+2)'(ai_d) - oi_v);
  end
endmodule

### src/radix2_fft_transform.sv
`timescale 1ns / 1ps
// Radix-2 decimation-in-time FFT, n = 2^log2_points complex points (2..MAX_POINTS).
// Samples are taken one per cycle and written at bit-reversed addresses; the
// n-th sample starts the transform, during which in_ch is not ready. One shared
// butterfly unit runs under a sequencer: each butterfly steps through two
// reads, a registered multiply, then two writes through the memory's single
// write port; inverse mode adds a divide-by-n pass (a read and a write per
// point). Results then leave in natural order through one output register,
// each bin read only once the previous one is in that register, bin_last
// marking bin n-1.
// Twiddles come from a Q1.23 quarter-wave cosine table rounded to
// TWIDDLE_BITS; products round to nearest and sums saturate to 23 bits.
// Configuration may only be written while the block is idle.
module radix2_fft_transform #(
  parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
  parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [r2fft_pkg::CFG_DATA_W-1:0]    cfg_data,
  r2fft_if.sink                               in_ch,
  r2fft_if.source                             out_ch
);
  import r2fft_pkg::*;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int LW = 3;
  localparam int TS = 24 - TWIDDLE_BITS;
  localparam logic [AW:0] ML = (AW+1)'(AW);

  typedef enum logic [3:0] {
    S_LOAD, S_RD_A, S_RD_B, S_MUL, S_WR_P, S_WR_Q, S_DIV_RD, S_DIV_WR,
    S_OUT_RD, S_OUT_WT
  } state_t;

  state_t state;
  logic         inverse_mode;
  logic [LW-1:0] log2_points;
  logic [AW:0]  load_count;
  logic [AW-1:0] idx, stage;  // butterfly index within stage, stage number
  logic [AW:0]  out_k;

  store_t mem_r [MAX_POINTS];
  store_t mem_i [MAX_POINTS];
  store_t rd_r, rd_i, ar, ai;

  // effective length
  logic [AW:0] l_eff;
  logic [AW:0] n_eff;
  always_comb begin
    l_eff = (AW+1)'(log2_points);
    if (l_eff == '0) l_eff = (AW+1)'(1);
    if (l_eff > ML) l_eff = ML;
    n_eff = (AW+1)'(1) << l_eff;
  end

  // bit reversal of the arrival index over l_eff bits
  logic [AW-1:0] wr_addr_load, full_rev;
  always_comb begin
    for (int b = 0; b < AW; b++) full_rev[b] = load_count[AW-1-b];
    wr_addr_load = full_rev >> (ML - l_eff);
  end

  // butterfly addressing: half = 2^stage; p = (idx with zero inserted at bit stage)
  logic [AW-1:0] half, lo_mask, j_lo, addr_p, addr_q;
  logic [5:0] t_ang;
  always_comb begin
    half = AW'(1) << stage;
    lo_mask = half - AW'(1);
    j_lo = idx & lo_mask;
    addr_p = ((idx & ~lo_mask) << 1) | j_lo;
    addr_q = addr_p | half;
    // t = j * 64 / m, m = 2^(stage+1)
    t_ang = 6'(({{(6 > AW ? 6 - AW : 1){1'b0}}, j_lo}) << (3'd5 - 3'(stage)));
  end

  // twiddle generation
  logic [24:0] cw, sw;
  logic signed [TWIDDLE_BITS-1:0] tw_r, tw_i, tw_r_q, tw_i_q;
  function automatic logic signed [TWIDDLE_BITS-1:0] tw_round(input logic [24:0] c);
    logic [24:0] mag;
    logic [TWIDDLE_BITS-1:0] lim;
    lim = {1'b0, {(TWIDDLE_BITS-1){1'b1}}};
    mag = {1'b0, c[23:0]};
    if (TS > 0) mag = (mag + (25'(1) << (TS - 1))) >> TS;
    if (mag > 25'(lim)) mag = 25'(lim);
    return c[24] ? -TWIDDLE_BITS'(mag) : TWIDDLE_BITS'(mag);
  endfunction
  always_comb begin
    cw = cos_q23(t_ang);
    sw = cos_q23(t_ang + 6'd48);
    tw_r = tw_round(cw);
    tw_i = inverse_mode ? -tw_round(sw) : tw_round(sw);
  end

  // the B operand comes straight from the read register, which keeps
  // addr_q from S_RD_B through S_WR_P so the products settle for both writes
  store_t pr, pi, qr, qi;
  r2fft_bfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bfly (
    .clk(clk), .wr(tw_r_q), .wi(tw_i_q), .ar(ar), .ai(ai), .br(rd_r), .bi(rd_i),
    .pr(pr), .pi(pi), .qr(qr), .qi(qi)
  );

  // rounding divide by n
  function automatic store_t div_n(input store_t v, input logic [AW:0] l);
    logic signed [STORE_W:0] s;
    s = (STORE_W+1)'(v) + ((STORE_W+1)'(1) <<< (l - (AW+1)'(1)));
    return STORE_W'(s >>> l);
  endfunction

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  store_t        mem_wd_r, mem_wd_i;
  always_comb begin
    mem_we = 1'b0; mem_wa = addr_p; mem_wd_r = pr; mem_wd_i = pi; mem_ra = addr_p;
    unique case (state)
      S_LOAD: begin
        mem_we = in_ch.valid; mem_wa = wr_addr_load;
        mem_wd_r = STORE_W'($signed(in_ch.data[IN_W-1:0]));
        mem_wd_i = STORE_W'($signed(in_ch.data[2*IN_W-1:IN_W]));
      end
      S_RD_A:   mem_ra = addr_p;
      S_RD_B:   mem_ra = addr_q;
      S_MUL:    mem_ra = addr_q;
      S_WR_P: begin mem_we = 1'b1; mem_ra = addr_q; end
      S_WR_Q: begin mem_we = 1'b1; mem_wa = addr_q; mem_wd_r = qr; mem_wd_i = qi; end
      S_DIV_RD: mem_ra = out_k[AW-1:0];
      S_DIV_WR: begin
        mem_we = 1'b1; mem_wa = out_k[AW-1:0];
        mem_wd_r = div_n(rd_r, l_eff); mem_wd_i = div_n(rd_i, l_eff);
      end
      S_OUT_RD: mem_ra = out_k[AW-1:0];
      S_OUT_WT: mem_ra = out_k[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd_r;
      mem_i[mem_wa] <= mem_wd_i;
    end
    rd_r <= mem_r[mem_ra];
    rd_i <= mem_i[mem_ra];
  end

  assign in_ch.ready = (state == S_LOAD);

  logic last_idx, last_stage;
  assign last_idx   = ({1'b0, idx} == (n_eff >> 1) - (AW+1)'(1));
  assign last_stage = ({1'b0, stage} == l_eff - (AW+1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      inverse_mode <= 1'b0;
      log2_points <= LW'(6);
      load_count <= '0;
      idx <= '0; stage <= '0; out_k <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INVERSE: inverse_mode <= cfg_data[0];
          REG_LOG2:    log2_points  <= cfg_data[LW-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_LOAD: if (in_ch.valid) begin
          // hold the arrival index modulo n
          if (((load_count + (AW+1)'(1)) & (n_eff - (AW+1)'(1))) == '0 ||
              load_count + (AW+1)'(1) >= n_eff) begin
            load_count <= '0; idx <= '0; stage <= '0;
            state <= S_RD_A;
          end else begin
            load_count <= load_count + (AW+1)'(1);
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          ar <= rd_r; ai <= rd_i;
          tw_r_q <= tw_r; tw_i_q <= tw_i;
          state <= S_MUL;
        end
        S_MUL: state <= S_WR_P;
        S_WR_P: state <= S_WR_Q;
        S_WR_Q: begin
          idx <= idx + AW'(1);
          if (last_idx) begin
            idx <= '0;
            stage <= stage + AW'(1);
            if (last_stage) begin
              out_k <= '0;
              state <= inverse_mode ? S_DIV_RD : S_OUT_RD;
            end else state <= S_RD_A;
          end else state <= S_RD_A;
        end
        S_DIV_RD: state <= S_DIV_WR;
        S_DIV_WR: begin
          if (out_k == n_eff - (AW+1)'(1)) begin
            out_k <= '0; state <= S_OUT_RD;
          end else begin
            out_k <= out_k + (AW+1)'(1); state <= S_DIV_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_WT;
        S_OUT_WT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.data <= {(out_k == n_eff - (AW+1)'(1)), rd_i, rd_r};
            if (out_k == n_eff - (AW+1)'(1)) begin
              out_k <= '0; state <= S_LOAD;
            end else begin
              out_k <= out_k + (AW+1)'(1); state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
      if (out_ch.valid && out_ch.ready &&
          !(state == S_OUT_WT)) out_ch.valid <= 1'b0;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == S_LOAD) else $error("ready outside load");
  a_no_out_in_bfly: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_P) |-> $past(state) == S_MUL) else $error("butterfly order");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    load_count < n_eff || state != S_LOAD) else $error("load count range");
endmodule
